// ===== sv/rrq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rrq_pkg
// Shared types, codes and default sizes of the round robin source queues.
// ----------------------------------------------------------------------------
package rrq_pkg;

    localparam int SOURCES_DEF      = 8;
    localparam int QUEUE_DEPTH_DEF  = 16;
    localparam int PAYLOAD_BITS_DEF = 32;
    localparam int ID_BITS_DEF      = 8;
    localparam int STATUS_W         = 3;
    localparam int WAIT_W           = 8;

    typedef enum logic {
        REQ_ENQ = 1'b0,
        REQ_DEQ = 1'b1
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        ST_ENQ    = 3'd0,
        ST_DEQ    = 3'd1,
        ST_EMPTY  = 3'd2,
        ST_FULL   = 3'd3,
        ST_NOSLOT = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_WAIT
    } t_state;

    typedef struct packed {
        logic accept;
        logic exec;
        logic load;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

// ===== sv/rrq_in_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rrq_in_if
// Request channel: enqueue or dequeue beat with camera id and payload.
// ----------------------------------------------------------------------------
interface rrq_in_if #(
    parameter int ID_BITS      = rrq_pkg::ID_BITS_DEF,
    parameter int PAYLOAD_BITS = rrq_pkg::PAYLOAD_BITS_DEF
);
    logic                    valid;
    logic                    ready;
    logic                    req_type;
    logic [ID_BITS-1:0]      camera_id;
    logic [PAYLOAD_BITS-1:0] payload;

    modport source (output valid, req_type, camera_id, payload, input ready);
    modport sink   (input valid, req_type, camera_id, payload, output ready);
endinterface
`default_nettype wire

// ===== sv/rrq_out_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rrq_out_if
// Result channel: one beat per request with status, item and queue level.
// ----------------------------------------------------------------------------
interface rrq_out_if #(
    parameter int ID_BITS      = rrq_pkg::ID_BITS_DEF,
    parameter int PAYLOAD_BITS = rrq_pkg::PAYLOAD_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic [rrq_pkg::STATUS_W-1:0]  status;
    logic [ID_BITS-1:0]            out_camera;
    logic [PAYLOAD_BITS-1:0]       out_payload;
    logic [rrq_pkg::WAIT_W-1:0]    items_waiting;
    logic                          data_available;

    modport source (output valid, status, out_camera, out_payload, items_waiting,
                    data_available, input ready);
    modport sink   (input valid, status, out_camera, out_payload, items_waiting,
                    data_available, output ready);
endinterface
`default_nettype wire

// ===== sv/rrq_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rrq_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module rrq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

// ===== sv/rrq_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rrq_ctrl
// Request sequencer: capture, execute, then load the result register.
// ----------------------------------------------------------------------------
module rrq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  rrq_pkg::t_sts i_sts,
    output rrq_pkg::t_cmd o_cmd
);
    rrq_pkg::t_state r_state;
    rrq_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rrq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            rrq_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = rrq_pkg::S_EXEC;
                end
            end
            rrq_pkg::S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = rrq_pkg::S_WAIT;
            end
            rrq_pkg::S_WAIT: begin
                // hold until the result register frees up
                if (i_sts.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = rrq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rrq_pkg::S_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

// ===== sv/rrq_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rrq_dp
// Datapath: slot table, per-slot FIFO pointers, round robin pick, FIFO
// memory and result register.
// ----------------------------------------------------------------------------
module rrq_dp #(
    parameter int SOURCES      = rrq_pkg::SOURCES_DEF,
    parameter int QUEUE_DEPTH  = rrq_pkg::QUEUE_DEPTH_DEF,
    parameter int PAYLOAD_BITS = rrq_pkg::PAYLOAD_BITS_DEF,
    parameter int ID_BITS      = rrq_pkg::ID_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  rrq_pkg::t_cmd                i_cmd,
    output rrq_pkg::t_sts                o_sts,
    input  logic                         i_req_type,
    input  logic [ID_BITS-1:0]           i_camera_id,
    input  logic [PAYLOAD_BITS-1:0]      i_payload,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output logic [rrq_pkg::STATUS_W-1:0] o_status,
    output logic [ID_BITS-1:0]           o_out_camera,
    output logic [PAYLOAD_BITS-1:0]      o_out_payload,
    output logic [rrq_pkg::WAIT_W-1:0]   o_items_waiting,
    output logic                         o_data_available
);
    localparam int SLOT_W    = $clog2(SOURCES);
    localparam int SU_W      = $clog2(SOURCES + 1);
    localparam int PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int FILL_W    = $clog2(QUEUE_DEPTH + 1);
    localparam int TOT_W     = $clog2(SOURCES * QUEUE_DEPTH + 1);
    localparam int ADDR_W    = SLOT_W + PTR_W;
    localparam int RAM_DEPTH = SOURCES << PTR_W;

    // captured request
    rrq_pkg::t_req           r_req;
    logic [ID_BITS-1:0]      r_cam;
    logic [PAYLOAD_BITS-1:0] r_data;

    // queue state
    logic [ID_BITS-1:0] r_slot_camera [SOURCES];
    logic [SU_W-1:0]    r_slots_used;
    logic [PTR_W-1:0]   r_head [SOURCES];
    logic [PTR_W-1:0]   r_tail [SOURCES];
    logic [FILL_W-1:0]  r_fill [SOURCES];
    logic [SLOT_W-1:0]  r_last;
    logic [TOT_W-1:0]   r_total;

    // pending result
    rrq_pkg::t_status   r_res_status;
    logic [ID_BITS-1:0] r_res_cam;

    // result register
    logic                         r_out_valid;
    logic [rrq_pkg::STATUS_W-1:0] r_out_status;
    logic [ID_BITS-1:0]           r_out_camera;
    logic [PAYLOAD_BITS-1:0]      r_out_payload;
    logic [rrq_pkg::WAIT_W-1:0]   r_out_waiting;
    logic                         r_out_avail;

    logic                    hit_any;
    logic [SLOT_W-1:0]       hit_slot;
    logic                    hi_any;
    logic [SLOT_W-1:0]       hi_slot;
    logic                    lo_any;
    logic [SLOT_W-1:0]       lo_slot;
    logic                    deq_ok;
    logic [SLOT_W-1:0]       pick;
    logic                    used_full;
    logic                    slot_ok;
    logic [SLOT_W-1:0]       enq_slot;
    logic [SLOT_W-1:0]       tgt;
    logic [FILL_W-1:0]       tgt_fill;
    logic [PTR_W-1:0]        tgt_head;
    logic [PTR_W-1:0]        tgt_tail;
    logic                    q_full;
    logic                    enq_ok;
    logic [PTR_W-1:0]        n_head;
    logic [PTR_W-1:0]        n_tail;
    rrq_pkg::t_status        n_status;
    logic                    ram_we;
    logic                    ram_re;
    logic [ADDR_W-1:0]       ram_waddr;
    logic [ADDR_W-1:0]       ram_raddr;
    logic [PAYLOAD_BITS-1:0] ram_rdata;
    logic [TOT_W+7:0]        tot_ext;

    // camera match and round robin pick over used slots
    always_comb begin
        hit_any  = 1'b0;
        hit_slot = '0;
        hi_any   = 1'b0;
        hi_slot  = '0;
        lo_any   = 1'b0;
        lo_slot  = '0;
        for (int i = SOURCES - 1; i >= 0; i--) begin
            if (SU_W'(i) < r_slots_used) begin
                if (r_slot_camera[i] == r_cam) begin
                    hit_any  = 1'b1;
                    hit_slot = SLOT_W'(i);
                end
                if (r_fill[i] != '0) begin
                    if (SLOT_W'(i) > r_last) begin
                        hi_any  = 1'b1;
                        hi_slot = SLOT_W'(i);
                    end else begin
                        lo_any  = 1'b1;
                        lo_slot = SLOT_W'(i);
                    end
                end
            end
        end
    end

    assign deq_ok    = hi_any | lo_any;
    assign pick      = hi_any ? hi_slot : lo_slot;
    assign used_full = (r_slots_used == SU_W'(SOURCES));
    assign slot_ok   = hit_any | ~used_full;
    assign enq_slot  = hit_any ? hit_slot : r_slots_used[SLOT_W-1:0];
    assign tgt       = (r_req == rrq_pkg::REQ_ENQ) ? enq_slot : pick;
    assign tgt_fill  = r_fill[tgt];
    assign tgt_head  = r_head[tgt];
    assign tgt_tail  = r_tail[tgt];
    assign q_full    = (tgt_fill == FILL_W'(QUEUE_DEPTH));
    assign enq_ok    = slot_ok & ~q_full;
    assign n_head    = (tgt_head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tgt_head + 1'b1;
    assign n_tail    = (tgt_tail == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tgt_tail + 1'b1;

    always_comb begin
        if (r_req == rrq_pkg::REQ_ENQ) begin
            if (!slot_ok) begin
                n_status = rrq_pkg::ST_NOSLOT;
            end else if (q_full) begin
                n_status = rrq_pkg::ST_FULL;
            end else begin
                n_status = rrq_pkg::ST_ENQ;
            end
        end else if (deq_ok) begin
            n_status = rrq_pkg::ST_DEQ;
        end else begin
            n_status = rrq_pkg::ST_EMPTY;
        end
    end

    assign ram_we    = i_cmd.exec & (r_req == rrq_pkg::REQ_ENQ) & enq_ok;
    assign ram_re    = i_cmd.exec & (r_req == rrq_pkg::REQ_DEQ) & deq_ok;
    assign ram_waddr = {tgt, tgt_tail};
    assign ram_raddr = {tgt, tgt_head};

    rrq_ram #(
        .WIDTH (PAYLOAD_BITS),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_data),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slots_used <= '0;
            r_last       <= '0;
            r_total      <= '0;
            r_out_valid  <= 1'b0;
            for (int i = 0; i < SOURCES; i++) begin
                r_head[i] <= '0;
                r_tail[i] <= '0;
                r_fill[i] <= '0;
            end
        end else begin
            if (ram_we) begin
                r_tail[tgt] <= n_tail;
                r_fill[tgt] <= tgt_fill + 1'b1;
                r_total     <= r_total + 1'b1;
                if (!hit_any) begin
                    r_slots_used <= r_slots_used + 1'b1;
                end
            end
            if (ram_re) begin
                r_head[tgt] <= n_head;
                r_fill[tgt] <= tgt_fill - 1'b1;
                r_total     <= r_total - 1'b1;
                r_last      <= pick;
            end
            if (i_cmd.load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign tot_ext = {8'd0, r_total};

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req  <= rrq_pkg::t_req'(i_req_type);
            r_cam  <= i_camera_id;
            r_data <= i_payload;
        end
        if (i_cmd.exec) begin
            r_res_status <= n_status;
            r_res_cam    <= r_slot_camera[tgt];
        end
        if (ram_we && !hit_any) begin
            r_slot_camera[tgt] <= r_cam;
        end
        if (i_cmd.load) begin
            r_out_status  <= r_res_status;
            r_out_camera  <= (r_res_status == rrq_pkg::ST_DEQ) ? r_res_cam : '0;
            r_out_payload <= (r_res_status == rrq_pkg::ST_DEQ) ? ram_rdata : '0;
            r_out_waiting <= tot_ext[7:0];
            r_out_avail   <= (r_total != '0);
        end
    end

    assign o_sts.out_free  = ~r_out_valid | i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_out_camera    = r_out_camera;
    assign o_out_payload   = r_out_payload;
    assign o_items_waiting = r_out_waiting;
    assign o_data_available = r_out_avail;
endmodule
`default_nettype wire

// ===== sv/round_robin_per_source_queues_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// round_robin_per_source_queues_top
// Per-camera FIFOs with round robin dequeue, one result beat per request.
// ----------------------------------------------------------------------------
// Each request is captured, then executed (slot lookup, round robin pick,
// pointer update, write or read of the shared FIFO memory), then its result
// is loaded into the output register once that register is free. The
// sequencer takes no new request until that result is loaded, so requests
// do not overlap. The output register lets the next request be taken while a
// result still waits. No clearing pass follows reset; the block takes
// requests as soon as reset is released.
module round_robin_per_source_queues_top #(
    parameter int SOURCES      = rrq_pkg::SOURCES_DEF,
    parameter int QUEUE_DEPTH  = rrq_pkg::QUEUE_DEPTH_DEF,
    parameter int PAYLOAD_BITS = rrq_pkg::PAYLOAD_BITS_DEF,
    parameter int ID_BITS      = rrq_pkg::ID_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rrq_in_if.sink     i_req,
    rrq_out_if.source  o_res
);
    rrq_pkg::t_cmd cmd;
    rrq_pkg::t_sts sts;
    logic          in_ready;

    rrq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    rrq_dp #(
        .SOURCES      (SOURCES),
        .QUEUE_DEPTH  (QUEUE_DEPTH),
        .PAYLOAD_BITS (PAYLOAD_BITS),
        .ID_BITS      (ID_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_req_type       (i_req.req_type),
        .i_camera_id      (i_req.camera_id),
        .i_payload        (i_req.payload),
        .i_out_ready      (o_res.ready),
        .o_out_valid      (o_res.valid),
        .o_status         (o_res.status),
        .o_out_camera     (o_res.out_camera),
        .o_out_payload    (o_res.out_payload),
        .o_items_waiting  (o_res.items_waiting),
        .o_data_available (o_res.data_available)
    );

    assign i_req.ready = in_ready;
endmodule
`default_nettype wire

// ===== sv/rrq_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rrq_checker
// Port-level checks on the result channel of the round robin source queues.
// ----------------------------------------------------------------------------
module rrq_checker #(
    parameter int PAYLOAD_BITS = rrq_pkg::PAYLOAD_BITS_DEF,
    parameter int ID_BITS      = rrq_pkg::ID_BITS_DEF
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [rrq_pkg::STATUS_W-1:0] i_status,
    input logic [ID_BITS-1:0]           i_out_camera,
    input logic [PAYLOAD_BITS-1:0]      i_out_payload,
    input logic [rrq_pkg::WAIT_W-1:0]   i_items_waiting,
    input logic                         i_data_available
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_status)
            && $stable(i_out_payload) && $stable(i_items_waiting))
        else $error("result beat changed while stalled");

    a_avail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_items_waiting != '0 |-> i_data_available)
        else $error("items waiting without data available");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == rrq_pkg::ST_EMPTY |-> !i_data_available
            && i_items_waiting == '0)
        else $error("empty dequeue while items wait");

    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status != rrq_pkg::ST_DEQ |-> i_out_camera == '0
            && i_out_payload == '0)
        else $error("item fields set on a non-dequeue result");
endmodule

bind round_robin_per_source_queues_top rrq_checker #(
    .PAYLOAD_BITS (PAYLOAD_BITS),
    .ID_BITS      (ID_BITS)
) u_rrq_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_res.valid),
    .i_out_ready      (o_res.ready),
    .i_status         (o_res.status),
    .i_out_camera     (o_res.out_camera),
    .i_out_payload    (o_res.out_payload),
    .i_items_waiting  (o_res.items_waiting),
    .i_data_available (o_res.data_available)
);
`default_nettype wire

// ===== bench/round_robin_per_source_queues_top_test.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// round_robin_per_source_queues_top_test
// Drives enqueue and dequeue requests into the per-camera queues through the
// request channel. Predicts each result from its own copy of the slot table,
// FIFO contents and round robin pointer, and checks every result beat in
// order. Random stall bursts on both channels, none near the end.
// ----------------------------------------------------------------------------
module round_robin_per_source_queues_top_test;

    localparam int NSLOT      = rrq_pkg::SOURCES_DEF;
    localparam int DEPTH      = rrq_pkg::QUEUE_DEPTH_DEF;
    localparam int CAM_W      = rrq_pkg::ID_BITS_DEF;
    localparam int DATA_W     = rrq_pkg::PAYLOAD_BITS_DEF;
    localparam int ST_W       = rrq_pkg::STATUS_W;
    localparam int WT_W       = rrq_pkg::WAIT_W;
    localparam int RAND_BEATS = 700;
    localparam int TAIL_BEATS = 60;
    localparam int STALL_MAX  = 1000;

    typedef struct packed {
        rrq_pkg::t_req     kind;
        logic [CAM_W-1:0]  cam;
        logic [DATA_W-1:0] data;
    } t_beat;

    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic [CAM_W-1:0]  cam;
        logic [DATA_W-1:0] data;
        logic [WT_W-1:0]   waiting;
        logic              avail;
    } t_result;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    rrq_in_if  #(.ID_BITS(CAM_W), .PAYLOAD_BITS(DATA_W)) req_ch ();
    rrq_out_if #(.ID_BITS(CAM_W), .PAYLOAD_BITS(DATA_W)) res_ch ();

    round_robin_per_source_queues_top #(
        .SOURCES      (NSLOT),
        .QUEUE_DEPTH  (DEPTH),
        .PAYLOAD_BITS (DATA_W),
        .ID_BITS      (CAM_W)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch)
    );

    always #6 i_clk = ~i_clk;

    // predictor state
    logic [CAM_W-1:0]  cam_of_slot [NSLOT];
    logic [DATA_W-1:0] fifo_mem    [NSLOT][DEPTH];
    int                rd_ptr      [NSLOT];
    int                wr_ptr      [NSLOT];
    int                depth_now   [NSLOT];
    int                slots_taken = 0;
    int                last_slot   = 0;
    int                held_total  = 0;

    t_beat            pending_beats [$];
    t_result          expected_results [$];
    t_beat            cur_beat;
    logic [CAM_W-1:0] known_cams [NSLOT];

    int beats_in     = 0;
    int results_seen = 0;
    int mismatches   = 0;
    int src_gap      = 0;
    int snk_gap      = 0;
    int stall_cycles = 0;
    int peak_waiting = 0;
    int status_count [5] = '{default: 0};

    function automatic t_result predict_response(t_beat b);
        t_result r;
        int      slot;
        int      idx;
        r = '0;
        if (b.kind == rrq_pkg::REQ_ENQ) begin
            slot = -1;
            for (int i = 0; i < slots_taken; i++)
                if (slot < 0 && cam_of_slot[i] == b.cam) slot = i;
            if (slot < 0 && slots_taken < NSLOT) begin
                slot = slots_taken;
                cam_of_slot[slot] = b.cam;
                rd_ptr[slot]      = 0;
                wr_ptr[slot]      = 0;
                depth_now[slot]   = 0;
                slots_taken++;
            end
            if (slot < 0) begin
                r.status = rrq_pkg::ST_NOSLOT;
            end else if (depth_now[slot] >= DEPTH) begin
                r.status = rrq_pkg::ST_FULL;
            end else begin
                r.status = rrq_pkg::ST_ENQ;
                fifo_mem[slot][wr_ptr[slot]] = b.data;
                wr_ptr[slot] = (wr_ptr[slot] + 1) % DEPTH;
                depth_now[slot]++;
                held_total++;
            end
        end else begin
            r.status = rrq_pkg::ST_EMPTY;
            if (held_total != 0 && slots_taken != 0) begin
                idx = last_slot % slots_taken;
                for (int k = 0; k < slots_taken; k++) begin
                    idx = (idx + 1) % slots_taken;
                    if (r.status == rrq_pkg::ST_EMPTY && depth_now[idx] != 0) begin
                        r.status  = rrq_pkg::ST_DEQ;
                        r.cam     = cam_of_slot[idx];
                        r.data    = fifo_mem[idx][rd_ptr[idx]];
                        rd_ptr[idx] = (rd_ptr[idx] + 1) % DEPTH;
                        depth_now[idx]--;
                        held_total--;
                        last_slot = idx;
                    end
                end
            end
        end
        r.waiting = WT_W'(held_total);
        r.avail   = (held_total != 0);
        return r;
    endfunction

    task automatic push_beat(rrq_pkg::t_req kind, logic [CAM_W-1:0] cam,
                             logic [DATA_W-1:0] data);
        t_beat b;
        b.kind = kind;
        b.cam  = cam;
        b.data = data;
        pending_beats = {pending_beats, b};
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                expected_results = {expected_results, predict_response(cur_beat)};
                beats_in++;
            end
            if (!req_ch.valid || req_ch.ready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    req_ch.valid <= 1'b0;
                end else if (pending_beats.size() > TAIL_BEATS && beats_in[6]
                             && $urandom_range(0, 7) == 0) begin
                    src_gap = $urandom_range(0, 17);
                    req_ch.valid <= 1'b0;
                end else if (pending_beats.size() != 0) begin
                    cur_beat = pending_beats.pop_front();
                    req_ch.valid     <= 1'b1;
                    req_ch.req_type  <= cur_beat.kind;
                    req_ch.camera_id <= cur_beat.cam;
                    req_ch.payload   <= cur_beat.data;
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                got.status  = res_ch.status;
                got.cam     = res_ch.out_camera;
                got.data    = res_ch.out_payload;
                got.waiting = res_ch.items_waiting;
                got.avail   = res_ch.data_available;
                results_seen++;
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d arrived with no request waiting for it",
                                 results_seen);
                end else begin
                    want = expected_results.pop_front();
                    status_count[want.status]++;
                    if (int'(want.waiting) > peak_waiting) peak_waiting = int'(want.waiting);
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("result %0d: got status %0d cam %h data %h waiting %0d avail %b",
                                     results_seen, got.status, got.cam, got.data,
                                     got.waiting, got.avail);
                            $display("  expected status %0d cam %h data %h waiting %0d avail %b",
                                     want.status, want.cam, want.data, want.waiting,
                                     want.avail);
                        end
                    end
                end
            end
            if (snk_gap > 0) begin
                snk_gap--;
                res_ch.ready <= 1'b0;
            end else if (pending_beats.size() > TAIL_BEATS && results_seen[5]
                         && $urandom_range(0, 7) == 0) begin
                snk_gap = $urandom_range(0, 17);
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_MAX) begin
                $display("no beat moved for %0d cycles", STALL_MAX);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial begin
        int kind;
        int len;
        int first_rand;
        req_ch.valid     = 1'b0;
        req_ch.req_type  = rrq_pkg::REQ_ENQ;
        req_ch.camera_id = '0;
        req_ch.payload   = '0;
        res_ch.ready     = 1'b0;

        known_cams = '{8'h00, 8'hFF, 8'h5A, 8'hA5, 8'h01, 8'h80, 8'h7E, 8'h33};

        push_beat(rrq_pkg::REQ_DEQ, CAM_W'($urandom), $urandom);
        push_beat(rrq_pkg::REQ_ENQ, known_cams[0], '0);
        push_beat(rrq_pkg::REQ_ENQ, known_cams[1], '1);
        push_beat(rrq_pkg::REQ_ENQ, known_cams[0], 32'h1234_5678);
        for (int i = 0; i < 4; i++) push_beat(rrq_pkg::REQ_DEQ, CAM_W'($urandom), $urandom);
        for (int i = 2; i < NSLOT; i++) push_beat(rrq_pkg::REQ_ENQ, known_cams[i], $urandom);
        push_beat(rrq_pkg::REQ_ENQ, 8'hC3, $urandom);
        push_beat(rrq_pkg::REQ_ENQ, known_cams[NSLOT-1], $urandom);
        for (int i = 0; i < 3; i++) push_beat(rrq_pkg::REQ_DEQ, CAM_W'($urandom), $urandom);

        first_rand = pending_beats.size();
        // fill every queue past full to reach the total ceiling
        for (int s = 0; s < NSLOT; s++)
            for (int i = 0; i <= DEPTH; i++)
                push_beat(rrq_pkg::REQ_ENQ, known_cams[s], $urandom);
        while (pending_beats.size() - first_rand < RAND_BEATS) begin
            kind = $urandom_range(0, 9);
            if (kind <= 4) begin
                len = $urandom_range(10, 40);
                for (int i = 0; i < len; i++)
                    if ($urandom_range(0, 99) < 55)
                        push_beat(rrq_pkg::REQ_ENQ, known_cams[$urandom_range(0, NSLOT-1)],
                                  $urandom);
                    else
                        push_beat(rrq_pkg::REQ_DEQ, CAM_W'($urandom), $urandom);
            end else if (kind <= 6) begin
                len = $urandom_range(DEPTH - 2, DEPTH + 4);
                kind = $urandom_range(0, NSLOT-1);
                for (int i = 0; i < len; i++)
                    push_beat(rrq_pkg::REQ_ENQ, known_cams[kind], $urandom);
            end else if (kind <= 8) begin
                len = $urandom_range(20, 60);
                for (int i = 0; i < len; i++)
                    push_beat(rrq_pkg::REQ_DEQ, CAM_W'($urandom), $urandom);
            end else begin
                len = $urandom_range(3, 10);
                for (int i = 0; i < len; i++)
                    push_beat(rrq_pkg::t_req'($urandom_range(0, 1)), CAM_W'($urandom),
                              $urandom);
            end
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_beats.size() != 0 || req_ch.valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (12) @(posedge i_clk);

        if (expected_results.size() != 0) begin
            mismatches++;
            $display("%0d results never arrived", expected_results.size());
        end
        $display("%0d requests: %0d enqueued, %0d dequeued, %0d empty dequeues,",
                 beats_in, status_count[rrq_pkg::ST_ENQ], status_count[rrq_pkg::ST_DEQ],
                 status_count[rrq_pkg::ST_EMPTY]);
        $display("%0d full-queue drops, %0d no-slot drops, peak %0d items held",
                 status_count[rrq_pkg::ST_FULL], status_count[rrq_pkg::ST_NOSLOT],
                 peak_waiting);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
`default_nettype wire
